/* rtl/dmps_pkg.sv */
// Shared types, constants and codes of the per-symbol directional movement unit.
package dmps_pkg;

  localparam int SYMBOLS_DEF = 256;

  localparam int SYM_W      = 8;
  localparam int PRICE_W    = 31;
  localparam int TS_W       = 64;
  localparam int LEN_W      = 32;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int TDATA_W    = ((SYM_W + PRICE_W + TS_W + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - SYM_W - PRICE_W - TS_W;

  // Restoring divider: one quotient bit per step.
  localparam int DIV_STEPS = TS_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PASS  = 2'd0,
    KIND_MINUS = 2'd1,
    KIND_PLUS  = 2'd2
  } kind_t;

  // One row of the per-symbol table.
  typedef struct packed {
    logic [TS_W-1:0]    cur_interval;
    logic [PRICE_W-1:0] cur_high;
    logic [PRICE_W-1:0] cur_low;
    logic [PRICE_W-1:0] prev_high;
    logic [PRICE_W-1:0] prev_low;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_CALC,
    ST_MINUS,
    ST_PLUS,
    ST_PASS
  } state_t;

  typedef struct packed {
    logic load_in;
    logic div_load;
    logic div_step;
    logic mem_rd;
    logic mem_upd;
    logic dm_calc;
    logic out_pass;
    logic out_minus;
    logic out_plus;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic is_pass;
    logic before_start;
    logic div_done;
    logic clr_done;
    logic no_prev;
    logic out_free;
  } status_t;

endpackage

/* rtl/dmps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dmps_ctrl.sv */
// Sequencer of the directional movement unit: steps one item through the datapath.
module dmps_ctrl
  import dmps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status.is_pass) begin
          state_next = ST_PASS;
        end else if (status.before_start) begin
          state_next = ST_IDLE;
        end else begin
          cmd.div_load = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.mem_upd = 1'b1;
        state_next  = ST_CALC;
      end
      ST_CALC: begin
        cmd.dm_calc = 1'b1;
        state_next  = status.no_prev ? ST_IDLE : ST_MINUS;
      end
      ST_MINUS: begin
        if (status.out_free) begin
          cmd.out_minus = 1'b1;
          state_next    = ST_PLUS;
        end
      end
      ST_PLUS: begin
        if (status.out_free) begin
          cmd.out_plus = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (status.out_free) begin
          cmd.out_pass = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dmps_dp.sv */
// Datapath: configuration registers, interval divider, symbol table and result register.
module dmps_dp
  import dmps_pkg::*;
#(
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TDATA_W-1:0]    s_tdata,
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast,
  input  cmd_t                  cmd,
  output status_t               status
);

  localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int MOD_W   = SYM_W + 17;
  localparam int MSH_W   = $clog2(SYM_W);

  // Configuration registers.
  logic              active;
  logic [LEN_W-1:0]  bar_len;
  logic [TS_W-1:0]   start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b1;
      bar_len    <= LEN_W'(1);
      start_time <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ACTIVE:       active     <= cfg_data[0];
        REG_INTERVAL_LEN: bar_len    <= cfg_data[LEN_W-1:0];
        REG_START_TIME:   start_time <= cfg_data[TS_W-1:0];
        default:          ;
      endcase
    end
  end

  // Captured input beat.
  logic               in_trade;
  logic [SYM_W-1:0]   in_sym;
  logic [PRICE_W-1:0] in_price;
  logic [TS_W-1:0]    in_ts;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_trade <= s_tuser;
      in_sym   <= s_tdata[SYM_W-1:0];
      in_price <= s_tdata[SYM_W +: PRICE_W];
      in_ts    <= s_tdata[SYM_W+PRICE_W +: TS_W];
    end
  end

  // Restoring divider for the interval number, and the symbol reduced modulo
  // the table depth by shifted subtractions during its first steps.
  logic [TS_W-1:0]   quo;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  dvs;
  logic [STEP_W-1:0] step_cnt;
  logic [SYM_W-1:0]  idx_work;
  logic [LEN_W:0]    rem_sh;
  logic              rem_ge;
  logic [MOD_W-1:0]  mod_ext;
  logic [MOD_W-1:0]  mod_sub;
  logic [MSH_W-1:0]  mod_shift;
  logic              mod_active;

  assign rem_sh     = {rem, quo[TS_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, dvs};
  assign mod_ext    = MOD_W'(idx_work);
  assign mod_shift  = MSH_W'(SYM_W - 1) - step_cnt[MSH_W-1:0];
  assign mod_sub    = MOD_W'(SYMBOLS) << mod_shift;
  assign mod_active = step_cnt < STEP_W'(SYM_W);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo      <= in_ts - start_time;
      rem      <= '0;
      dvs      <= (bar_len == '0) ? LEN_W'(1) : bar_len;
      idx_work <= in_sym;
    end else if (cmd.div_step) begin
      quo <= {quo[TS_W-2:0], rem_ge};
      rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, dvs}) : rem_sh[LEN_W-1:0];
      if (mod_active && mod_ext >= mod_sub) begin
        idx_work <= SYM_W'(mod_ext - mod_sub);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.div_load) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  // Clearing pass after reset.
  logic [IDX_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + IDX_W'(1);
    end
  end

  // Symbol table.
  logic [IDX_W-1:0] addr;
  entry_t           rd_entry;
  entry_t           new_entry;
  logic [ENTRY_W-1:0] rd_raw;

  assign addr     = IDX_W'(idx_work);
  assign rd_entry = entry_t'(rd_raw);

  dmps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.clr_step | cmd.mem_upd),
    .waddr (cmd.clr_step ? clr_cnt : addr),
    .wdata (cmd.clr_step ? '0 : ENTRY_W'(new_entry)),
    .re    (cmd.mem_rd),
    .raddr (addr),
    .rdata (rd_raw)
  );

  always_comb begin
    new_entry = rd_entry;
    if (rd_entry.cur_interval == quo) begin
      if (in_price > rd_entry.cur_high) begin
        new_entry.cur_high = in_price;
      end
      if (in_price < rd_entry.cur_low) begin
        new_entry.cur_low = in_price;
      end
    end else begin
      new_entry.prev_low     = rd_entry.cur_low;
      new_entry.prev_high    = rd_entry.cur_high;
      new_entry.cur_interval = quo;
      new_entry.cur_low      = in_price;
      new_entry.cur_high     = in_price;
    end
  end

  // Directional movement from the updated row.
  logic [PRICE_W-1:0]      op_ch, op_cl, op_ph, op_pl;
  logic signed [PRICE_W:0] up, down;
  logic [PRICE_W-1:0]      plus_move, minus_move;

  always_ff @(posedge clk) begin
    if (cmd.mem_upd) begin
      op_ch <= new_entry.cur_high;
      op_cl <= new_entry.cur_low;
      op_ph <= new_entry.prev_high;
      op_pl <= new_entry.prev_low;
    end
  end

  assign up   = $signed({1'b0, op_ch}) - $signed({1'b0, op_ph});
  assign down = $signed({1'b0, op_pl}) - $signed({1'b0, op_cl});

  always_ff @(posedge clk) begin
    if (cmd.dm_calc) begin
      plus_move  <= (up > down && !up[PRICE_W] && up != '0) ? up[PRICE_W-1:0] : '0;
      minus_move <= (down > up && !down[PRICE_W] && down != '0) ? down[PRICE_W-1:0] : '0;
    end
  end

  // Result register.
  kind_t              out_kind;
  logic [SYM_W-1:0]   out_sym;
  logic [PRICE_W-1:0] out_val;
  logic [TS_W-1:0]    out_ts;
  logic               out_last;
  logic               out_load;

  assign out_load = cmd.out_pass | cmd.out_minus | cmd.out_plus;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sym <= in_sym;
      out_ts  <= in_ts;
      priority if (cmd.out_minus) begin
        out_kind <= KIND_MINUS;
        out_val  <= minus_move;
        out_last <= 1'b0;
      end else if (cmd.out_plus) begin
        out_kind <= KIND_PLUS;
        out_val  <= plus_move;
        out_last <= 1'b1;
      end else begin
        out_kind <= KIND_PASS;
        out_val  <= '0;
        out_last <= 1'b1;
      end
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_ts, out_val, out_sym};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  // Status toward the sequencer.
  assign status.is_pass      = !active || !in_trade;
  assign status.before_start = in_ts < start_time;
  assign status.div_done     = step_cnt == STEP_W'(DIV_STEPS - 1);
  assign status.clr_done     = clr_cnt == IDX_W'(SYMBOLS - 1);
  assign status.no_prev      = (op_pl == '0) && (op_ph == '0);
  assign status.out_free     = !m_tvalid || m_tready;

endmodule

/* rtl/directional_movement_per_symbol_unit.sv */
// Top level of the per-symbol Wilder directional movement unit.
//
// The unit takes one beat at a time. A trade beat is placed in its bar
// interval, (timestamp - start_time) / bar length, and updates that symbol's
// row of the table: the current interval, its high and low, and the previous
// interval's high and low. When the previous bar is known the unit sends two
// beats, -DM (last low) then +DM (last high); when it is not, or when the trade
// lies before start_time, nothing is sent. A non-trade beat, or any beat while
// active is zero, comes back as one pass-through beat. For a trade, a check
// state comes first; the interval number then comes from a restoring divider
// that produces one quotient bit per cycle, followed by a table read, an
// update, the movement arithmetic and the two result beats. The result
// register lets the next beat start while the last result still waits for
// m_tready. After reset the table is cleared one row per cycle with s_tready
// held low; configuration writes are taken during that time as always. Symbol
// indexes are reduced modulo SYMBOLS, and an interval length of zero counts
// as one.
module directional_movement_per_symbol_unit
  import dmps_pkg::*;
#(
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: index 0 active, 1 bar length, 2 start_time.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input beats.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,  // in_symbol, in_price, in_timestamp, zero pad
  input  logic                  s_tuser,  // in_is_trade
  // Result beats.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,  // out_symbol, out_value, out_timestamp, zero pad
  output logic [KIND_W-1:0]     m_tuser,  // out_kind
  output logic                  m_tlast   // out_last
);

  cmd_t    cmd;
  status_t status;

  dmps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dmps_dp #(
    .SYMBOLS (SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef NO_ASSERTIONS
  // Only one kind of result is loaded in a cycle.
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.out_pass, cmd.out_minus, cmd.out_plus}))
    else $error("two result loads in one cycle");

  // A result is never loaded over a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_pass || cmd.out_minus || cmd.out_plus) |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while stalled");

  // A minus beat is always followed by its plus beat before a new input.
  a_minus_then_plus: assert property (@(posedge clk) disable iff (rst)
    cmd.out_minus |=> !s_tready)
    else $error("input accepted between the two movement beats");

  // The table is never written while a new beat may be accepted.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.mem_upd || cmd.clr_step))
    else $error("table written while waiting for input");
`endif

endmodule

/* test/tb_directional_movement_per_symbol_unit.sv */
// Self-checking testbench of the per-symbol directional movement unit.
module tb_directional_movement_per_symbol_unit;
  import dmps_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 12;
  // The limit leaves a wide margin over the slowest correct run, the clearing
  // pass after reset and the long receiver hold.
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 100;    // quiet cycles after the last result
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_LEN    = 600;
  localparam int PHASE_BEATS = 210;
  localparam int PRINT_MAX   = 40;

  // Positions of the fields inside tdata, lowest first.
  localparam int VAL_LSB = SYM_W;
  localparam int TS_LSB  = SYM_W + PRICE_W;

  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [TS_W-1:0]    TS_MAX    = '1;

  typedef struct {
    bit                is_trade;
    bit [SYM_W-1:0]    sym;
    bit [PRICE_W-1:0]  price;
    bit [TS_W-1:0]     ts;
  } trade_t;

  typedef struct {
    kind_t             kind;
    bit [SYM_W-1:0]    sym;
    bit [PRICE_W-1:0]  value;
    bit [TS_W-1:0]     ts;
    bit                last;
  } dm_beat_t;

  typedef enum bit {ROW_BEAT, ROW_WRITE} row_op_t;

  // One line of the directed script. A beat row with n_typed of -1 is checked
  // against the predictor; otherwise n_typed results are written out by hand.
  typedef struct {
    row_op_t                op;
    trade_t                 it;
    logic [CFG_IDX_W-1:0]   idx;
    bit [CFG_DATA_W-1:0]    val;
    int                     n_typed;
    bit [PRICE_W-1:0]       minus_v;
    bit [PRICE_W-1:0]       plus_v;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;  // in_symbol, in_price, in_timestamp, zero pad
  logic                  s_tuser = 1'b0;  // in_is_trade
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;  // out_symbol, out_value, out_timestamp, zero pad
  logic [KIND_W-1:0]     m_tuser;  // out_kind
  logic                  m_tlast;  // out_last

  directional_movement_per_symbol_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Mirror of the configuration registers and of the per-symbol bar table.
  // The table starts out cleared, exactly like the unit after its clearing pass.
  bit                 act_q = 1'b1;
  bit [LEN_W-1:0]     len_q = 1;
  bit [TS_W-1:0]      start_q = '0;
  bit [TS_W-1:0]      bar_num [SYMBOLS_DEF];
  bit [PRICE_W-1:0]   bar_high [SYMBOLS_DEF];
  bit [PRICE_W-1:0]   bar_low [SYMBOLS_DEF];
  bit [PRICE_W-1:0]   last_high [SYMBOLS_DEF];
  bit [PRICE_W-1:0]   last_low [SYMBOLS_DEF];

  dm_beat_t    movement_out [2];   // results of the latest predicted trade
  dm_beat_t    movement_due [$];   // results still waiting to come out
  script_row_t script [$];

  // Stimulus state of the random part.
  bit [TS_W-1:0] ts_now;
  longint        price_walk [SYMBOLS_DEF];
  int            tx_idle_pct = 16;
  int            rx_idle_pct = 73;
  bit            hold_go = 1'b0;
  int            hold_left = 0;
  bit            hold_taken = 1'b0;
  int            errors = 0;
  int            cycles = 0;

  // Works out the results that one accepted beat causes and updates the table.
  function automatic int predict_movement(input trade_t it);
    bit [TS_W-1:0] divisor;
    bit [TS_W-1:0] bar;
    int            s;
    longint        up;
    longint        down;
    bit [PRICE_W-1:0] plus_v;
    bit [PRICE_W-1:0] minus_v;
    if (!act_q || !it.is_trade) begin
      movement_out[0] = '{KIND_PASS, it.sym, '0, it.ts, 1'b1};
      return 1;
    end
    // Trades stamped before the start time leave the table alone.
    if (it.ts < start_q) return 0;
    divisor = len_q;
    if (divisor == 0) divisor = 1;
    bar = (it.ts - start_q) / divisor;
    s = it.sym % SYMBOLS_DEF;
    if (bar_num[s] == bar) begin
      if (it.price > bar_high[s]) bar_high[s] = it.price;
      if (it.price < bar_low[s]) bar_low[s] = it.price;
    end else begin
      last_low[s] = bar_low[s];
      last_high[s] = bar_high[s];
      bar_num[s] = bar;
      bar_low[s] = it.price;
      bar_high[s] = it.price;
    end
    if (last_low[s] == 0 && last_high[s] == 0) return 0;
    up = longint'({33'd0, bar_high[s]}) - longint'({33'd0, last_high[s]});
    down = longint'({33'd0, last_low[s]}) - longint'({33'd0, bar_low[s]});
    // A tie between the two moves gives zero on both sides.
    plus_v = (up > down && up > 0) ? up[PRICE_W-1:0] : '0;
    minus_v = (down > up && down > 0) ? down[PRICE_W-1:0] : '0;
    movement_out[0] = '{KIND_MINUS, it.sym, minus_v, it.ts, 1'b0};
    movement_out[1] = '{KIND_PLUS, it.sym, plus_v, it.ts, 1'b1};
    return 2;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= PRINT_MAX)
      $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic add_beat(input bit trd, input bit [SYM_W-1:0] sym,
                          input bit [PRICE_W-1:0] price, input bit [TS_W-1:0] ts,
                          input int n, input bit [PRICE_W-1:0] mv,
                          input bit [PRICE_W-1:0] pv);
    script_row_t row;
    row.op = ROW_BEAT;
    row.it = '{trd, sym, price, ts};
    row.idx = REG_ACTIVE;
    row.val = '0;
    row.n_typed = n;
    row.minus_v = mv;
    row.plus_v = pv;
    script.push_back(row);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                           input bit [CFG_DATA_W-1:0] val);
    script_row_t row;
    row.op = ROW_WRITE;
    row.it = '{1'b0, '0, '0, '0};
    row.idx = idx;
    row.val = val;
    row.n_typed = 0;
    row.minus_v = '0;
    row.plus_v = '0;
    script.push_back(row);
  endtask

  // One register write; the enable drops on the next edge, and the task returns only
  // after it is sampled low, so back-to-back writes never touch it twice in a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input bit [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ACTIVE:       act_q = val[0];
      REG_INTERVAL_LEN: len_q = val[LEN_W-1:0];
      REG_START_TIME:   start_q = val;
      default:          ;
    endcase
    @(posedge clk);
  endtask

  // Offers one beat, waits until it is taken and files its expected results.
  task automatic send_trade(input trade_t it, input int n_typed,
                            input bit [PRICE_W-1:0] mv, input bit [PRICE_W-1:0] pv);
    int n;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.is_trade;
    s_tdata <= {{(TDATA_W - SYM_W - PRICE_W - TS_W){1'b0}}, it.ts, it.price, it.sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = predict_movement(it);
    if (n_typed < 0) begin
      for (int i = 0; i < n; i++) movement_due.push_back(movement_out[i]);
    end else if (n_typed == 1) begin
      movement_due.push_back('{KIND_PASS, it.sym, '0, it.ts, 1'b1});
    end else if (n_typed == 2) begin
      movement_due.push_back('{KIND_MINUS, it.sym, mv, it.ts, 1'b0});
      movement_due.push_back('{KIND_PLUS, it.sym, pv, it.ts, 1'b1});
    end
  endtask

  // Lets every expected result arrive, then gives the unit time to finish a
  // trade that produces nothing, so that the next register write hits it idle.
  task automatic settle_quiet();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (movement_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random trade: mostly a handful of busy symbols with prices drifting
  // around a per-symbol level, so that bars widen, roll over and produce
  // movements; a share of full-range prices, zero prices, odd symbols,
  // non-trade messages and trades stamped before the start time.
  function automatic trade_t next_random_trade();
    trade_t it;
    int     r;
    longint p;
    it.is_trade = ($urandom_range(0, 99) >= 8);
    if ($urandom_range(0, 99) < 80) it.sym = SYM_W'($urandom_range(0, 7));
    else it.sym = SYM_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      it.price = PRICE_W'($urandom);
    end else if (r < 12) begin
      it.price = '0;
    end else begin
      p = price_walk[it.sym] + longint'($urandom_range(0, 400)) - 200;
      if (p < 1) p = 1;
      if (p > longint'(PRICE_MAX)) p = longint'(PRICE_MAX);
      price_walk[it.sym] = p;
      it.price = p[PRICE_W-1:0];
    end
    // Mostly short steps, so several trades share a bar; now and then a jump.
    if ($urandom_range(0, 99) < 70) ts_now += $urandom_range(0, len_q / 4);
    else ts_now += $urandom_range(0, 3 * len_q);
    it.ts = ts_now;
    if (start_q > 1000 && $urandom_range(0, 99) < 5)
      it.ts = start_q - 1 - $urandom_range(0, 999);
    return it;
  endfunction

  // Receiver: random stalls at the rate of the current phase, plus one long
  // hold-off, counted here, that lets the unit back up into its input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_taken) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_taken <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result checker: every accepted beat must match the oldest expectation.
  always @(posedge clk) begin
    dm_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (movement_due.size() == 0) begin
        flag_mismatch("beat with no result due", m_tdata[63:0], '0);
      end else begin
        want = movement_due.pop_front();
        if (m_tuser != want.kind) flag_mismatch("out_kind", m_tuser, want.kind);
        if (m_tdata[SYM_W-1:0] != want.sym)
          flag_mismatch("out_symbol", m_tdata[SYM_W-1:0], want.sym);
        if (m_tdata[VAL_LSB +: PRICE_W] != want.value)
          flag_mismatch("out_value", m_tdata[VAL_LSB +: PRICE_W], want.value);
        if (m_tdata[TS_LSB +: TS_W] != want.ts)
          flag_mismatch("out_timestamp", m_tdata[TS_LSB +: TS_W], want.ts);
        if (m_tlast != want.last) flag_mismatch("out_last", m_tlast, want.last);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    bit [TS_W-1:0] phase_start;
    bit [LEN_W-1:0] phase_len;

    // Directed part. Right after reset: interval length one, start time zero.
    add_beat(1'b0, 8'd0, PRICE_MAX, TS_MAX, 1, '0, '0);     // pass-through, all ones
    add_beat(1'b0, 8'd255, '0, '0, 1, '0, '0);              // pass-through, all zeros
    add_beat(1'b1, 8'd5, 31'd100, 64'd0, 0, '0, '0);        // fresh row, bar 0: no history
    add_beat(1'b1, 8'd5, 31'd200, 64'd1, 2, 31'd0, 31'd100); // new bar, up move
    add_beat(1'b1, 8'd5, 31'd50, 64'd1, -1, '0, '0);        // same bar widens the low
    add_beat(1'b1, 8'd5, PRICE_MAX, 64'd2, -1, '0, '0);     // largest price
    add_beat(1'b1, 8'd5, '0, 64'd3, 2, PRICE_MAX, 31'd0);   // largest down move
    add_beat(1'b1, 8'd5, '0, 64'd4, 0, '0, '0);             // previous bar all zero
    add_beat(1'b1, 8'd7, 31'd100, 64'd10, 0, '0, '0);
    add_beat(1'b1, 8'd7, 31'd200, 64'd11, -1, '0, '0);
    add_beat(1'b1, 8'd7, '0, 64'd11, 2, 31'd0, 31'd0);      // equal moves cancel
    add_beat(1'b1, 8'd255, 31'd1, TS_MAX, -1, '0, '0);      // last symbol, last bar
    add_beat(1'b1, 8'd255, 31'd3, TS_MAX, -1, '0, '0);
    add_write(REG_ACTIVE, 64'd0);
    add_beat(1'b1, 8'd9, 31'd123, 64'd77, 1, '0, '0);       // inactive: trade passes
    add_write(REG_ACTIVE, 64'd1);
    add_write(REG_START_TIME, 64'd1000);
    add_beat(1'b1, 8'd9, 31'd10, 64'd999, 0, '0, '0);       // just before the start
    add_beat(1'b1, 8'd9, 31'd10, 64'd0, 0, '0, '0);
    add_beat(1'b1, 8'd9, 31'd10, 64'd1000, -1, '0, '0);
    add_write(REG_INTERVAL_LEN, 64'd0);                     // zero length acts as one
    add_beat(1'b1, 8'd9, 31'd20, 64'd1001, -1, '0, '0);
    add_write(REG_INTERVAL_LEN, 64'hFFFF_FFFF);
    add_write(REG_START_TIME, 64'd0);
    add_beat(1'b1, 8'd9, 31'd5, TS_MAX, -1, '0, '0);
    add_beat(1'b0, 8'd9, 31'd1, 64'd5, 1, '0, '0);

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;

    // The unit clears its table after reset with s_tready low; the first
    // beat simply waits for it.
    foreach (script[i]) begin
      if (script[i].op == ROW_WRITE) begin
        settle_quiet();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_trade(script[i].it, script[i].n_typed, script[i].minus_v, script[i].plus_v);
      end
    end

    // Random part in three phases: a busy receiver, then a slow sender, then
    // no idling at all with one long receiver hold-off.
    for (int phase = 0; phase < 3; phase++) begin
      settle_quiet();
      case (phase)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 73;
          phase_len = 7;
          phase_start = {1'b0, 31'($urandom), 32'($urandom)} | 64'h1_0000_0000;
          ts_now = phase_start;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 16;
          phase_len = 1000;
          phase_start = '0;
          ts_now = {16'd0, 16'($urandom), 32'($urandom)};
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          phase_len = $urandom_range(20, 200);
          phase_start = {2'b10, 30'($urandom), 32'($urandom)};
          ts_now = phase_start;
        end
      endcase
      write_reg(REG_INTERVAL_LEN, {32'd0, phase_len});
      write_reg(REG_START_TIME, phase_start);
      foreach (price_walk[i]) price_walk[i] = $urandom_range(1000, 2000000000);
      if (phase == 2) hold_go = 1'b1;
      repeat (PHASE_BEATS) send_trade(next_random_trade(), -1, '0, '0);
    end

    settle_quiet();
    if (movement_due.size() != 0)
      flag_mismatch("results never delivered", movement_due.size(), 0);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dmps_pkg.sv
rtl/dmps_ram.sv
rtl/dmps_ctrl.sv
rtl/dmps_dp.sv
rtl/directional_movement_per_symbol_unit.sv
test/tb_directional_movement_per_symbol_unit.sv
